/* rtl/rc_gesture_mode_controller_defines.svh */
// assertion macros for the rc gesture mode controller checker
// used by rcg_checker.sv, no other dependencies
`ifndef RC_GESTURE_MODE_CONTROLLER_DEFINES_SVH
`define RC_GESTURE_MODE_CONTROLLER_DEFINES_SVH

// same-cycle implication, quiet during reset
`define RCG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define RCG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rcg_pkg.sv */
// types and constants for the rc gesture mode controller
// no dependencies; used by rc_gesture_mode_controller
`timescale 1ns / 1ps

package rcg_pkg;

  localparam int CFG_W    = 48;
  localparam int IDX_W    = 3;
  localparam int FIELD_W  = 16;
  localparam int TIME_W   = 32;
  localparam int QUOT_W   = 32;
  localparam int CNT_W    = $clog2(QUOT_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEL,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_DONE,
    ST_OUT
  } state_t;

  typedef enum logic [IDX_W-1:0] {
    REG_RUDDER_POINTS = 3'd0,
    REG_RUDDER_SERVO  = 3'd1,
    REG_SAIL_PULSE    = 3'd2,
    REG_SAIL_SERVO    = 3'd3,
    REG_THRESHOLDS    = 3'd4,
    REG_HOLD_MS       = 3'd5,
    REG_IMMUNITY_MS   = 3'd6
  } cfg_reg_t;

  localparam logic OP_TICK     = 1'b0;
  localparam logic OP_SET_MODE = 1'b1;
  localparam logic MODE_MANUAL = 1'b0;
  localparam logic MODE_AUTO   = 1'b1;

  localparam logic PHASE_RUDDER = 1'b0;
  localparam logic PHASE_SAIL   = 1'b1;

  localparam logic [47:0] RST_RUDDER_POINTS = 48'd8053161985125;
  localparam logic [31:0] RST_RUDDER_SERVO  = 32'd39321750;
  localparam logic [31:0] RST_SAIL_PULSE    = 32'd131073000;
  localparam logic [31:0] RST_SAIL_SERVO    = 32'd39321750;
  localparam logic [47:0] RST_THRESHOLDS    = 48'd8160509953100;
  localparam logic [15:0] RST_HOLD_MS       = 16'd2000;
  localparam logic [15:0] RST_IMMUNITY_MS   = 16'd3000;

  localparam logic [16:0] RST_RUDDER_SUM =
    {1'b0, RST_RUDDER_SERVO[15:0]} + {1'b0, RST_RUDDER_SERVO[31:16]};
  localparam logic [16:0] RST_SAIL_SUM =
    {1'b0, RST_SAIL_SERVO[15:0]} + {1'b0, RST_SAIL_SERVO[31:16]};
  localparam logic [15:0] RST_RUDDER_CMD = RST_RUDDER_SUM[16:1];
  localparam logic [15:0] RST_SAIL_CMD   = RST_SAIL_SUM[16:1];

endpackage

/* rtl/rc_gesture_mode_controller.sv */
// rc gesture mode controller: servo maps, gesture detection and mode control
// depends on rcg_pkg
// result offered in the cycle after the request when no map runs; each non-zero pulse adds one map
// a new request is taken only once the last result has left the output; out_stall holds the result there
// each map: 17x17 multiply then 32 shared divider steps, the divider skipped when its input span is zero
// rst is synchronous: config registers return to defaults, commands to servo midpoints
`timescale 1ns / 1ps

module rc_gesture_mode_controller (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rcg_pkg::IDX_W-1:0]        cfg_index,
  input  logic [rcg_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             op,
  input  logic [rcg_pkg::FIELD_W-1:0]      sail_pulse_us,
  input  logic [rcg_pkg::FIELD_W-1:0]      rudder_pulse_us,
  input  logic [rcg_pkg::TIME_W-1:0]       now_ms,
  input  logic                             new_mode,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rcg_pkg::FIELD_W-1:0]      rudder_command,
  output logic [rcg_pkg::FIELD_W-1:0]      sail_command,
  output logic                             mode,
  output logic                             record_fired,
  output logic                             start_fired,
  output logic                             kill_fired
);

  // config registers
  logic [47:0] rudder_pulse_points;
  logic [31:0] rudder_servo_limits;
  logic [31:0] sail_pulse_limits;
  logic [31:0] sail_servo_limits;
  logic [47:0] gesture_thresholds;
  logic [15:0] hold_time_ms;
  logic [15:0] immunity_ms;

  // control state
  rcg_pkg::state_t state, state_next;
  logic        mode_bit;
  logic [31:0] auto_start_time;
  logic        record_armed;
  logic [31:0] record_start_time;
  logic        start_armed;
  logic [31:0] start_gesture_time;
  logic [15:0] rudder_cmd_reg;
  logic [15:0] sail_cmd_reg;
  logic [2:0]  event_flags;

  // request latch and map datapath
  logic        phase;
  logic [15:0] sail_l;
  logic [15:0] rud_l;
  logic [15:0] x_op, a_op, b_op, c_op, d_op, lo_op, hi_op;
  logic signed [33:0] prod;
  logic signed [16:0] den;
  logic        zero_span;
  logic [31:0] num;
  logic [15:0] den_mag;
  logic [15:0] rem;
  logic        neg;
  logic [rcg_pkg::CNT_W-1:0] cnt;

  logic accept;
  assign accept = in_valid && !in_stall;

  // gesture decode on the incoming request
  logic sail_down, rud_left, rud_right, immune, hold_rec, hold_start;
  logic rec_fire, start_fire;
  always_comb begin
    sail_down  = (sail_pulse_us == '0) || (sail_pulse_us < gesture_thresholds[15:0]);
    rud_left   = (rudder_pulse_us != '0) && (rudder_pulse_us < gesture_thresholds[31:16]);
    rud_right  = (rudder_pulse_us != '0) && (rudder_pulse_us > gesture_thresholds[47:32]);
    immune     = (now_ms - auto_start_time) < {16'd0, immunity_ms};
    hold_rec   = (now_ms - record_start_time) >= {16'd0, hold_time_ms};
    hold_start = (now_ms - start_gesture_time) >= {16'd0, hold_time_ms};
    rec_fire   = sail_down && rud_right && record_armed && hold_rec;
    start_fire = sail_down && rud_left && start_armed && hold_start;
  end

  // operand selection for the map in progress
  logic [16:0] rud_mid_sum;
  logic [15:0] rud_mid;
  logic [15:0] sel_x;
  always_comb begin
    rud_mid_sum = {1'b0, rudder_servo_limits[15:0]} + {1'b0, rudder_servo_limits[31:16]};
    rud_mid     = rud_mid_sum[16:1];
    sel_x       = (phase == rcg_pkg::PHASE_RUDDER) ? rud_l : sail_l;
  end

  // shared arithmetic
  logic signed [16:0] dx, dd;
  logic signed [33:0] prod_mul;
  logic signed [33:0] prod_abs;
  logic signed [16:0] den_abs;
  logic [16:0] rem_sh, rem_diff;
  logic        rem_ge;
  logic signed [34:0] q_s, v_s, lo_s, hi_s;
  logic [15:0] clamped;
  always_comb begin
    dx       = $signed({1'b0, x_op}) - $signed({1'b0, a_op});
    dd       = $signed({1'b0, d_op}) - $signed({1'b0, c_op});
    prod_mul = dx * dd;
    prod_abs = prod[33] ? -prod : prod;
    den_abs  = den[16] ? -den : den;
    rem_sh   = {rem, num[31]};
    rem_diff = rem_sh - {1'b0, den_mag};
    rem_ge   = rem_sh >= {1'b0, den_mag};
    q_s      = neg ? -$signed({3'b000, num}) : $signed({3'b000, num});
    v_s      = q_s + $signed({19'd0, c_op});
    lo_s     = $signed({19'd0, lo_op});
    hi_s     = $signed({19'd0, hi_op});
    priority if (v_s < lo_s) begin
      clamped = lo_op;
    end else if (v_s > hi_s) begin
      clamped = hi_op;
    end else begin
      clamped = v_s[15:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rcg_pkg::ST_IDLE: begin
        if (accept) begin
          if (op == rcg_pkg::OP_SET_MODE) begin
            state_next = rcg_pkg::ST_OUT;
          end else if ((rudder_pulse_us != '0) || (sail_pulse_us != '0)) begin
            state_next = rcg_pkg::ST_SEL;
          end else begin
            state_next = rcg_pkg::ST_OUT;
          end
        end
      end
      rcg_pkg::ST_SEL:  state_next = rcg_pkg::ST_MUL;
      rcg_pkg::ST_MUL:  state_next = rcg_pkg::ST_PREP;
      rcg_pkg::ST_PREP: state_next = zero_span ? rcg_pkg::ST_DONE : rcg_pkg::ST_DIV;
      rcg_pkg::ST_DIV: begin
        if (cnt == rcg_pkg::CNT_W'(rcg_pkg::QUOT_W - 1)) begin
          state_next = rcg_pkg::ST_DONE;
        end
      end
      rcg_pkg::ST_DONE: begin
        if ((phase == rcg_pkg::PHASE_RUDDER) && (sail_l != '0)) begin
          state_next = rcg_pkg::ST_SEL;
        end else begin
          state_next = rcg_pkg::ST_OUT;
        end
      end
      rcg_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_next = rcg_pkg::ST_IDLE;
        end
      end
      default: state_next = rcg_pkg::ST_IDLE;
    endcase
  end

  // handshake and result outputs
  always_comb begin
    in_stall       = (state != rcg_pkg::ST_IDLE);
    out_valid      = (state == rcg_pkg::ST_OUT);
    rudder_command = rudder_cmd_reg;
    sail_command   = sail_cmd_reg;
    mode           = mode_bit;
    record_fired   = event_flags[0];
    start_fired    = event_flags[1];
    kill_fired     = event_flags[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rudder_pulse_points <= rcg_pkg::RST_RUDDER_POINTS;
      rudder_servo_limits <= rcg_pkg::RST_RUDDER_SERVO;
      sail_pulse_limits   <= rcg_pkg::RST_SAIL_PULSE;
      sail_servo_limits   <= rcg_pkg::RST_SAIL_SERVO;
      gesture_thresholds  <= rcg_pkg::RST_THRESHOLDS;
      hold_time_ms        <= rcg_pkg::RST_HOLD_MS;
      immunity_ms         <= rcg_pkg::RST_IMMUNITY_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rcg_pkg::REG_RUDDER_POINTS: rudder_pulse_points <= cfg_data;
        rcg_pkg::REG_RUDDER_SERVO:  rudder_servo_limits <= cfg_data[31:0];
        rcg_pkg::REG_SAIL_PULSE:    sail_pulse_limits   <= cfg_data[31:0];
        rcg_pkg::REG_SAIL_SERVO:    sail_servo_limits   <= cfg_data[31:0];
        rcg_pkg::REG_THRESHOLDS:    gesture_thresholds  <= cfg_data;
        rcg_pkg::REG_HOLD_MS:       hold_time_ms        <= cfg_data[15:0];
        rcg_pkg::REG_IMMUNITY_MS:   immunity_ms         <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // mode, gestures and events, all settled when the request is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_bit           <= rcg_pkg::MODE_MANUAL;
      auto_start_time    <= '0;
      record_armed       <= 1'b0;
      record_start_time  <= '0;
      start_armed        <= 1'b0;
      start_gesture_time <= '0;
      event_flags        <= '0;
    end else if (accept) begin
      if (op == rcg_pkg::OP_SET_MODE) begin
        mode_bit <= new_mode;
        if (new_mode == rcg_pkg::MODE_AUTO) begin
          auto_start_time <= now_ms;
        end
      end else if (mode_bit == rcg_pkg::MODE_AUTO) begin
        if (!immune && !sail_down) begin
          event_flags  <= 3'b100;
          mode_bit     <= rcg_pkg::MODE_MANUAL;
          record_armed <= 1'b0;
          start_armed  <= 1'b0;
        end else begin
          event_flags <= '0;
        end
      end else begin
        event_flags <= {1'b0, start_fire, rec_fire};
        if (sail_down && rud_right) begin
          if (!record_armed) begin
            record_armed      <= 1'b1;
            record_start_time <= now_ms;
          end else if (hold_rec) begin
            record_armed <= 1'b0;
          end
        end else begin
          record_armed <= 1'b0;
        end
        if (sail_down && rud_left) begin
          if (!start_armed) begin
            start_armed        <= 1'b1;
            start_gesture_time <= now_ms;
          end else if (hold_start) begin
            start_armed <= 1'b0;
          end
        end else begin
          start_armed <= 1'b0;
        end
      end
    end
  end

  // servo commands
  always_ff @(posedge clk) begin
    if (rst) begin
      rudder_cmd_reg <= rcg_pkg::RST_RUDDER_CMD;
      sail_cmd_reg   <= rcg_pkg::RST_SAIL_CMD;
    end else if (state == rcg_pkg::ST_DONE) begin
      if (phase == rcg_pkg::PHASE_RUDDER) begin
        rudder_cmd_reg <= clamped;
      end else begin
        sail_cmd_reg <= clamped;
      end
    end
  end

  // map datapath, shared by rudder and sail
  always_ff @(posedge clk) begin
    unique case (state)
      rcg_pkg::ST_IDLE: begin
        if (accept) begin
          sail_l <= sail_pulse_us;
          rud_l  <= rudder_pulse_us;
          phase  <= (rudder_pulse_us != '0) ? rcg_pkg::PHASE_RUDDER : rcg_pkg::PHASE_SAIL;
        end
      end
      rcg_pkg::ST_SEL: begin
        x_op <= sel_x;
        if (phase == rcg_pkg::PHASE_RUDDER) begin
          lo_op <= rudder_servo_limits[15:0];
          hi_op <= rudder_servo_limits[31:16];
          if (rud_l <= rudder_pulse_points[31:16]) begin
            a_op <= rudder_pulse_points[15:0];
            b_op <= rudder_pulse_points[31:16];
            c_op <= rudder_servo_limits[31:16];
            d_op <= rud_mid;
          end else begin
            a_op <= rudder_pulse_points[31:16];
            b_op <= rudder_pulse_points[47:32];
            c_op <= rud_mid;
            d_op <= rudder_servo_limits[15:0];
          end
        end else begin
          lo_op <= sail_servo_limits[15:0];
          hi_op <= sail_servo_limits[31:16];
          a_op  <= sail_pulse_limits[15:0];
          b_op  <= sail_pulse_limits[31:16];
          c_op  <= sail_servo_limits[15:0];
          d_op  <= sail_servo_limits[31:16];
        end
      end
      rcg_pkg::ST_MUL: begin
        prod      <= prod_mul;
        den       <= $signed({1'b0, b_op}) - $signed({1'b0, a_op});
        zero_span <= (a_op == b_op);
      end
      rcg_pkg::ST_PREP: begin
        rem <= '0;
        cnt <= '0;
        if (zero_span) begin
          num <= '0;
          neg <= 1'b0;
        end else begin
          num     <= prod_abs[31:0];
          den_mag <= den_abs[15:0];
          neg     <= prod[33] ^ den[16];
        end
      end
      rcg_pkg::ST_DIV: begin
        cnt <= cnt + 1'b1;
        if (rem_ge) begin
          rem <= rem_diff[15:0];
          num <= {num[30:0], 1'b1};
        end else begin
          rem <= rem_sh[15:0];
          num <= {num[30:0], 1'b0};
        end
      end
      rcg_pkg::ST_DONE: begin
        if (phase == rcg_pkg::PHASE_RUDDER) begin
          phase <= rcg_pkg::PHASE_SAIL;
        end
      end
      rcg_pkg::ST_OUT: ;
      default: ;
    endcase
  end

endmodule

/* rtl/rcg_checker.sv */
// port-level checks for the rc gesture mode controller, bound to the top level
// depends on rc_gesture_mode_controller_defines.svh and rc_gesture_mode_controller
`timescale 1ns / 1ps
`include "rc_gesture_mode_controller_defines.svh"

module rcg_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] rudder_command,
  input logic [15:0] sail_command,
  input logic        mode,
  input logic        record_fired,
  input logic        start_fired,
  input logic        kill_fired
);

  `RCG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(rudder_command) && $stable(sail_command) && $stable(mode), "stalled result changed")
  `RCG_ASSERT_NOW(a_busy_while_out, out_valid, in_stall, "request taken while result pending")
  `RCG_ASSERT_NOW(a_kill_alone, out_valid && kill_fired, !record_fired && !start_fired, "kill together with a gesture")
  `RCG_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall, "request taken without going busy")
  `RCG_ASSERT_NEXT(a_out_single, out_valid && !out_stall, !out_valid, "result offered twice")

endmodule

bind rc_gesture_mode_controller rcg_checker u_rcg_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .rudder_command (rudder_command),
  .sail_command   (sail_command),
  .mode           (mode),
  .record_fired   (record_fired),
  .start_fired    (start_fired),
  .kill_fired     (kill_fired)
);

/* tb/rc_gesture_mode_controller_tb.sv */
// self-checking testbench for rc_gesture_mode_controller: servo maps, gestures and mode control
// needs rcg_pkg and the controller rtl; holds its own bit-exact model of the controller
`timescale 1ns / 1ps

module rc_gesture_mode_controller_tb;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int DRAIN_CYCLES = 80;
  localparam logic [rcg_pkg::IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic                        op;
    logic [rcg_pkg::FIELD_W-1:0] sail;
    logic [rcg_pkg::FIELD_W-1:0] rudder;
    logic [rcg_pkg::TIME_W-1:0]  now;
    logic                        new_mode;
  } request_t;

  typedef struct packed {
    logic [rcg_pkg::FIELD_W-1:0] rudder;
    logic [rcg_pkg::FIELD_W-1:0] sail;
    logic                        mode;
    logic                        record;
    logic                        start;
    logic                        kill;
  } status_t;

  typedef enum {STICK_RIGHT, STICK_LEFT, STICK_ANY} stick_t;
  typedef enum {STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY} stall_style_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [rcg_pkg::IDX_W-1:0] cfg_index = '0;
  logic [rcg_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic op = rcg_pkg::OP_TICK;
  logic [rcg_pkg::FIELD_W-1:0] sail_pulse_us = '0;
  logic [rcg_pkg::FIELD_W-1:0] rudder_pulse_us = '0;
  logic [rcg_pkg::TIME_W-1:0] now_ms = '0;
  logic new_mode = rcg_pkg::MODE_MANUAL;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [rcg_pkg::FIELD_W-1:0] rudder_command;
  logic [rcg_pkg::FIELD_W-1:0] sail_command;
  logic mode;
  logic record_fired;
  logic start_fired;
  logic kill_fired;

  rc_gesture_mode_controller dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .sail_pulse_us(sail_pulse_us), .rudder_pulse_us(rudder_pulse_us),
    .now_ms(now_ms), .new_mode(new_mode),
    .out_valid(out_valid), .out_stall(out_stall),
    .rudder_command(rudder_command), .sail_command(sail_command), .mode(mode),
    .record_fired(record_fired), .start_fired(start_fired), .kill_fired(kill_fired)
  );

  // register mirror
  logic [47:0] cfg_rudder_points;
  logic [31:0] cfg_rudder_servo;
  logic [31:0] cfg_sail_pulse;
  logic [31:0] cfg_sail_servo;
  logic [47:0] cfg_thresholds;
  logic [15:0] cfg_hold_ms;
  logic [15:0] cfg_immunity_ms;

  // controller state mirror
  logic ctl_mode;
  logic [31:0] auto_since_ms;
  logic rec_armed;
  logic [31:0] rec_since_ms;
  logic go_armed;
  logic [31:0] go_since_ms;
  logic [15:0] rudder_cmd;
  logic [15:0] sail_cmd;
  logic rec_evt, go_evt, kill_evt;

  request_t pending_reqs[$];
  status_t status_due[$];
  request_t held_req;
  status_t got_status, want_status;
  logic [31:0] clock_ms;

  int queued = 0;
  int accepted = 0;
  int results_taken = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int burst_left = 1;
  int gap_left = 0;
  int style_left = 0;
  int n_record = 0;
  int n_start = 0;
  int n_kill = 0;
  int settings_used = 1;
  stall_style_t stall_style = STALL_NONE;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint span_map(longint x, longint a, longint b, longint c, longint d);
    if (a == b) return c;
    return (x - a) * (d - c) / (b - a) + c;
  endfunction

  function automatic longint clamp_to(longint x, longint lo, longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic status_t advance_controller(request_t r);
    longint rud, sail, lo, hi, mid, ctr, v;
    logic down, left, right;
    logic [31:0] held;
    rud = r.rudder;
    sail = r.sail;
    ctr = cfg_rudder_points[31:16];
    if (r.op == rcg_pkg::OP_SET_MODE) begin
      ctl_mode = r.new_mode;
      if (r.new_mode == rcg_pkg::MODE_AUTO) auto_since_ms = r.now;
    end else begin
      rec_evt = 1'b0;
      go_evt = 1'b0;
      kill_evt = 1'b0;
      if (rud > 0) begin
        lo = cfg_rudder_servo[15:0];
        hi = cfg_rudder_servo[31:16];
        mid = (lo + hi) / 2;
        if (rud <= ctr) v = span_map(rud, cfg_rudder_points[15:0], ctr, hi, mid);
        else v = span_map(rud, ctr, cfg_rudder_points[47:32], mid, lo);
        rudder_cmd = 16'(clamp_to(v, lo, hi));
      end
      if (sail > 0) begin
        lo = cfg_sail_servo[15:0];
        hi = cfg_sail_servo[31:16];
        v = span_map(sail, cfg_sail_pulse[15:0], cfg_sail_pulse[31:16], lo, hi);
        sail_cmd = 16'(clamp_to(v, lo, hi));
      end
      down = (sail == 0) || (sail < longint'(cfg_thresholds[15:0]));
      left = (rud > 0) && (rud < longint'(cfg_thresholds[31:16]));
      right = (rud > 0) && (rud > longint'(cfg_thresholds[47:32]));
      if (ctl_mode == rcg_pkg::MODE_AUTO) begin
        held = r.now - auto_since_ms;
        if (!down && held >= {16'd0, cfg_immunity_ms}) begin
          kill_evt = 1'b1;
          ctl_mode = rcg_pkg::MODE_MANUAL;
          rec_armed = 1'b0;
          go_armed = 1'b0;
        end
      end else begin
        if (down && right) begin
          held = r.now - rec_since_ms;
          if (!rec_armed) begin
            rec_armed = 1'b1;
            rec_since_ms = r.now;
          end else if (held >= {16'd0, cfg_hold_ms}) begin
            rec_evt = 1'b1;
            rec_armed = 1'b0;
          end
        end else begin
          rec_armed = 1'b0;
        end
        if (down && left) begin
          held = r.now - go_since_ms;
          if (!go_armed) begin
            go_armed = 1'b1;
            go_since_ms = r.now;
          end else if (held >= {16'd0, cfg_hold_ms}) begin
            go_evt = 1'b1;
            go_armed = 1'b0;
          end
        end else begin
          go_armed = 1'b0;
        end
      end
    end
    return status_t'{rudder_cmd, sail_cmd, ctl_mode, rec_evt, go_evt, kill_evt};
  endfunction

  function automatic void push_req(logic o, logic [15:0] s, logic [15:0] r, logic [31:0] t,
                                   logic nm);
    pending_reqs.push_back(request_t'{o, s, r, t, nm});
    queued++;
  endfunction

  function automatic logic [15:0] any_pulse();
    if ($urandom_range(0, 7) == 0) return 16'd0;
    return 16'($urandom_range(1, 40000));
  endfunction

  function automatic logic [15:0] pick_sail(bit down);
    int thr = cfg_thresholds[15:0];
    if (down) begin
      if (thr <= 1 || $urandom_range(0, 4) == 0) return 16'd0;
      return 16'($urandom_range(1, (thr - 1 > 40000) ? 40000 : thr - 1));
    end
    if (thr > 40000) return 16'($urandom_range(1, 40000));
    return 16'($urandom_range((thr == 0) ? 1 : thr, 40000));
  endfunction

  function automatic logic [15:0] pick_rudder(stick_t side);
    int lt = cfg_thresholds[31:16];
    int rt = cfg_thresholds[47:32];
    case (side)
      STICK_RIGHT: begin
        if (rt >= 40000) return 16'($urandom_range(1, 40000));
        return 16'($urandom_range(rt + 1, 40000));
      end
      STICK_LEFT: begin
        if (lt <= 1) return 16'($urandom_range(0, 40000));
        return 16'($urandom_range(1, (lt - 1 > 40000) ? 40000 : lt - 1));
      end
      default: begin
        if ($urandom_range(0, 5) == 0) return 16'd0;
        if ($urandom_range(0, 1) == 0) return 16'($urandom_range(500, 2500));
        return 16'($urandom_range(1, 40000));
      end
    endcase
  endfunction

  task automatic write_reg(logic [rcg_pkg::IDX_W-1:0] idx, logic [rcg_pkg::CFG_W-1:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    case (idx)
      rcg_pkg::REG_RUDDER_POINTS: cfg_rudder_points = d[47:0];
      rcg_pkg::REG_RUDDER_SERVO: cfg_rudder_servo = d[31:0];
      rcg_pkg::REG_SAIL_PULSE: cfg_sail_pulse = d[31:0];
      rcg_pkg::REG_SAIL_SERVO: cfg_sail_servo = d[31:0];
      rcg_pkg::REG_THRESHOLDS: cfg_thresholds = d[47:0];
      rcg_pkg::REG_HOLD_MS: cfg_hold_ms = d[15:0];
      rcg_pkg::REG_IMMUNITY_MS: cfg_immunity_ms = d[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_phase(int k);
    case (k)
      1: begin
        write_reg(rcg_pkg::REG_RUDDER_POINTS, {16'd1875, 16'd1500, 16'd1125});
        write_reg(rcg_pkg::REG_RUDDER_SERVO, {16'd0, 16'd600, 16'd150});
        write_reg(rcg_pkg::REG_SAIL_PULSE, {16'd0, 16'd2000, 16'd1000});
        write_reg(rcg_pkg::REG_SAIL_SERVO, {16'd0, 16'd600, 16'd150});
        write_reg(rcg_pkg::REG_THRESHOLDS, {16'd1900, 16'd1300, 16'd1100});
        write_reg(rcg_pkg::REG_HOLD_MS, 48'd300);
        write_reg(rcg_pkg::REG_IMMUNITY_MS, 48'd500);
      end
      2: begin
        // zero spans everywhere, no hold, no immunity
        write_reg(rcg_pkg::REG_RUDDER_POINTS, '0);
        write_reg(rcg_pkg::REG_RUDDER_SERVO, '0);
        write_reg(rcg_pkg::REG_SAIL_PULSE, '0);
        write_reg(rcg_pkg::REG_SAIL_SERVO, '0);
        write_reg(rcg_pkg::REG_THRESHOLDS, '0);
        write_reg(rcg_pkg::REG_HOLD_MS, '0);
        write_reg(rcg_pkg::REG_IMMUNITY_MS, '0);
        write_reg(REG_SPARE, 48'({$urandom, $urandom}));
      end
      3: begin
        write_reg(rcg_pkg::REG_RUDDER_POINTS, '1);
        write_reg(rcg_pkg::REG_RUDDER_SERVO, '1);
        write_reg(rcg_pkg::REG_SAIL_PULSE, '1);
        write_reg(rcg_pkg::REG_SAIL_SERVO, '1);
        write_reg(rcg_pkg::REG_THRESHOLDS, '1);
        write_reg(rcg_pkg::REG_HOLD_MS, '1);
        write_reg(rcg_pkg::REG_IMMUNITY_MS, '1);
      end
      4: begin
        // inverted points and limits
        write_reg(rcg_pkg::REG_RUDDER_POINTS, {16'd1125, 16'd1500, 16'd1875});
        write_reg(rcg_pkg::REG_RUDDER_SERVO, {16'd0, 16'd150, 16'd600});
        write_reg(rcg_pkg::REG_SAIL_PULSE, {16'd0, 16'd1000, 16'd2000});
        write_reg(rcg_pkg::REG_SAIL_SERVO, {16'd0, 16'd100, 16'd900});
        write_reg(rcg_pkg::REG_THRESHOLDS, {16'd1900, 16'd1300, 16'd1100});
        write_reg(rcg_pkg::REG_HOLD_MS, 48'd1000);
        write_reg(rcg_pkg::REG_IMMUNITY_MS, 48'd2000);
      end
      5: begin
        write_reg(rcg_pkg::REG_RUDDER_POINTS, {16'($urandom_range(0, 40000)),
                                               16'($urandom_range(0, 40000)),
                                               16'($urandom_range(0, 40000))});
        write_reg(rcg_pkg::REG_RUDDER_SERVO, {16'($urandom), 32'($urandom)});
        write_reg(rcg_pkg::REG_SAIL_PULSE, {16'($urandom), 32'($urandom)});
        write_reg(rcg_pkg::REG_SAIL_SERVO, {16'($urandom), 32'($urandom)});
        write_reg(rcg_pkg::REG_THRESHOLDS, {16'($urandom_range(0, 40000)),
                                            16'($urandom_range(0, 40000)),
                                            16'($urandom_range(0, 40000))});
        write_reg(rcg_pkg::REG_HOLD_MS, {32'($urandom), 16'($urandom_range(0, 3000))});
        write_reg(rcg_pkg::REG_IMMUNITY_MS, {32'($urandom), 16'($urandom_range(0, 5000))});
      end
      6: begin
        write_reg(rcg_pkg::REG_RUDDER_POINTS, {16'($urandom_range(1700, 2100)),
                                               16'($urandom_range(1400, 1600)),
                                               16'($urandom_range(900, 1300))});
        write_reg(rcg_pkg::REG_RUDDER_SERVO, {16'd0, 16'($urandom_range(500, 4095)),
                                              16'($urandom_range(0, 500))});
        write_reg(rcg_pkg::REG_SAIL_PULSE, {16'd0, 16'($urandom_range(1500, 2200)),
                                            16'($urandom_range(800, 1500))});
        write_reg(rcg_pkg::REG_SAIL_SERVO, {16'd0, 16'($urandom_range(0, 4095)),
                                            16'($urandom_range(0, 4095))});
        write_reg(rcg_pkg::REG_THRESHOLDS, {16'($urandom_range(1600, 2000)),
                                            16'($urandom_range(1000, 1400)),
                                            16'($urandom_range(900, 1400))});
        write_reg(rcg_pkg::REG_HOLD_MS, 48'($urandom_range(0, 800)));
        write_reg(rcg_pkg::REG_IMMUNITY_MS, 48'($urandom_range(0, 1500)));
      end
      default: begin
        write_reg(rcg_pkg::REG_RUDDER_POINTS, rcg_pkg::RST_RUDDER_POINTS);
        write_reg(rcg_pkg::REG_RUDDER_SERVO, 48'(rcg_pkg::RST_RUDDER_SERVO));
        write_reg(rcg_pkg::REG_SAIL_PULSE, 48'(rcg_pkg::RST_SAIL_PULSE));
        write_reg(rcg_pkg::REG_SAIL_SERVO, 48'(rcg_pkg::RST_SAIL_SERVO));
        write_reg(rcg_pkg::REG_THRESHOLDS, rcg_pkg::RST_THRESHOLDS);
        write_reg(rcg_pkg::REG_HOLD_MS, 48'(rcg_pkg::RST_HOLD_MS));
        write_reg(rcg_pkg::REG_IMMUNITY_MS, 48'(rcg_pkg::RST_IMMUNITY_MS));
        write_reg(REG_SPARE, '1);
      end
    endcase
  endtask

  task automatic fill_random(int n);
    int goal;
    stick_t side;
    goal = queued + n;
    while (queued < goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // held gesture, sometimes broken
          side = ($urandom_range(0, 1) == 0) ? STICK_RIGHT : STICK_LEFT;
          repeat ($urandom_range(2, 10)) begin
            clock_ms += $urandom_range(0, cfg_hold_ms / 3 + 50);
            if ($urandom_range(0, 9) == 0)
              push_req(rcg_pkg::OP_TICK, pick_sail($urandom_range(0, 1)),
                       pick_rudder(STICK_ANY), clock_ms, 1'($urandom));
            else
              push_req(rcg_pkg::OP_TICK, pick_sail(1'b1), pick_rudder(side), clock_ms,
                       1'($urandom));
          end
        end
        3, 4: begin
          push_req(rcg_pkg::OP_SET_MODE, any_pulse(), any_pulse(), clock_ms, rcg_pkg::MODE_AUTO);
          repeat ($urandom_range(1, 8)) begin
            clock_ms += $urandom_range(0, cfg_immunity_ms / 2 + 100);
            push_req(rcg_pkg::OP_TICK, pick_sail($urandom_range(0, 2) != 0),
                     pick_rudder(STICK_ANY), clock_ms, 1'($urandom));
          end
          if ($urandom_range(0, 3) == 0)
            push_req(rcg_pkg::OP_SET_MODE, any_pulse(), any_pulse(), clock_ms,
                     rcg_pkg::MODE_MANUAL);
        end
        5: begin
          clock_ms += $urandom_range(0, 500);
          push_req(rcg_pkg::OP_SET_MODE, any_pulse(), any_pulse(), clock_ms, 1'($urandom));
        end
        default: begin
          if ($urandom_range(0, 19) == 0) clock_ms += $urandom;
          else clock_ms += $urandom_range(0, 1000);
          push_req(rcg_pkg::OP_TICK, any_pulse(), pick_rudder(STICK_ANY), clock_ms,
                   1'($urandom));
        end
      endcase
    end
  endtask

  task automatic wait_drained();
    while (results_taken < queued) @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 1;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        status_due.push_back(advance_controller(held_req));
        accepted++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          held_req = pending_reqs.pop_front();
          op <= held_req.op;
          sail_pulse_us <= held_req.sail;
          rudder_pulse_us <= held_req.rudder;
          now_ms <= held_req.now;
          new_mode <= held_req.new_mode;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            if ($urandom_range(0, 9) == 0) gap_left <= $urandom_range(20, 60);
            else if ($urandom_range(0, 2) == 0) gap_left <= 0;
            else gap_left <= $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and output stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_status = status_t'{rudder_command, sail_command, mode,
                               record_fired, start_fired, kill_fired};
        if (status_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: rud %0d sail %0d mode %0b rec %0b start %0b kill %0b",
                     got_status.rudder, got_status.sail, got_status.mode,
                     got_status.record, got_status.start, got_status.kill);
        end else begin
          want_status = status_due.pop_front();
          results_taken++;
          n_record += want_status.record;
          n_start += want_status.start;
          n_kill += want_status.kill;
          if (got_status !== want_status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d: expected rud %0d sail %0d mode %0b events %b%b%b",
                       results_taken, want_status.rudder, want_status.sail, want_status.mode,
                       want_status.record, want_status.start, want_status.kill);
              $display("  got rud %0d sail %0d mode %0b events %b%b%b",
                       got_status.rudder, got_status.sail, got_status.mode,
                       got_status.record, got_status.start, got_status.kill);
            end
          end
        end
      end
      if (style_left == 0) begin
        stall_style <= stall_style_t'($urandom_range(0, 3));
        style_left <= $urandom_range(50, 600);
      end else begin
        style_left <= style_left - 1;
      end
      case (stall_style)
        STALL_NONE: out_stall <= 1'b0;
        STALL_SPARSE: out_stall <= ($urandom_range(0, 2) == 0);
        STALL_PERIODIC: out_stall <= ((cycle_count % 16) < 11);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("rc_gesture_mode_controller_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int k;
    cfg_rudder_points = rcg_pkg::RST_RUDDER_POINTS;
    cfg_rudder_servo = rcg_pkg::RST_RUDDER_SERVO;
    cfg_sail_pulse = rcg_pkg::RST_SAIL_PULSE;
    cfg_sail_servo = rcg_pkg::RST_SAIL_SERVO;
    cfg_thresholds = rcg_pkg::RST_THRESHOLDS;
    cfg_hold_ms = rcg_pkg::RST_HOLD_MS;
    cfg_immunity_ms = rcg_pkg::RST_IMMUNITY_MS;
    ctl_mode = rcg_pkg::MODE_MANUAL;
    auto_since_ms = '0;
    rec_armed = 1'b0;
    rec_since_ms = '0;
    go_armed = 1'b0;
    go_since_ms = '0;
    rec_evt = 1'b0;
    go_evt = 1'b0;
    kill_evt = 1'b0;
    rudder_cmd = 16'((32'(cfg_rudder_servo[15:0]) + cfg_rudder_servo[31:16]) / 2);
    sail_cmd = 16'((32'(cfg_sail_servo[15:0]) + cfg_sail_servo[31:16]) / 2);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed requests on reset registers
    push_req(rcg_pkg::OP_TICK, 16'd0, 16'd0, 32'd0, rcg_pkg::MODE_MANUAL);
    push_req(rcg_pkg::OP_TICK, 16'd40000, 16'd40000, 32'd5, rcg_pkg::MODE_MANUAL);
    push_req(rcg_pkg::OP_TICK, 16'd1, 16'd1, 32'd10, rcg_pkg::MODE_MANUAL);
    push_req(rcg_pkg::OP_TICK, 16'd1100, 16'd1300, 32'd20, rcg_pkg::MODE_MANUAL);
    push_req(rcg_pkg::OP_TICK, 16'd1099, 16'd1901, 32'd100, rcg_pkg::MODE_MANUAL);
    push_req(rcg_pkg::OP_TICK, 16'd1099, 16'd1901, 32'd1000, rcg_pkg::MODE_MANUAL);
    push_req(rcg_pkg::OP_TICK, 16'd1099, 16'd1901, 32'd2100, rcg_pkg::MODE_MANUAL);
    push_req(rcg_pkg::OP_TICK, 16'd0, 16'd1900, 32'd2200, rcg_pkg::MODE_MANUAL);
    push_req(rcg_pkg::OP_TICK, 16'd0, 16'd1299, 32'd3000, rcg_pkg::MODE_MANUAL);
    push_req(rcg_pkg::OP_TICK, 16'd0, 16'd1299, 32'd5000, rcg_pkg::MODE_MANUAL);
    push_req(rcg_pkg::OP_TICK, 16'd1500, 16'd1500, 32'd5100, rcg_pkg::MODE_MANUAL);
    push_req(rcg_pkg::OP_TICK, 16'd1099, 16'd1950, 32'd5200, rcg_pkg::MODE_MANUAL);
    push_req(rcg_pkg::OP_SET_MODE, 16'd40000, 16'd40000, 32'd5300, rcg_pkg::MODE_AUTO);
    push_req(rcg_pkg::OP_TICK, 16'd1099, 16'd1950, 32'd9000, rcg_pkg::MODE_MANUAL);
    push_req(rcg_pkg::OP_SET_MODE, 16'd0, 16'd0, 32'd9100, rcg_pkg::MODE_MANUAL);
    // record armed before auto mode still completes
    push_req(rcg_pkg::OP_TICK, 16'd1099, 16'd1950, 32'd9200, rcg_pkg::MODE_MANUAL);
    push_req(rcg_pkg::OP_SET_MODE, 16'd1500, 16'd1500, 32'd10000, rcg_pkg::MODE_AUTO);
    push_req(rcg_pkg::OP_TICK, 16'd1500, 16'd1500, 32'd12999, rcg_pkg::MODE_MANUAL);
    push_req(rcg_pkg::OP_SET_MODE, 16'd1500, 16'd1500, 32'd13000, rcg_pkg::MODE_AUTO);
    push_req(rcg_pkg::OP_TICK, 16'd1500, 16'd1500, 32'd15999, rcg_pkg::MODE_AUTO);
    push_req(rcg_pkg::OP_TICK, 16'd1500, 16'd1500, 32'd16000, rcg_pkg::MODE_AUTO);
    push_req(rcg_pkg::OP_SET_MODE, 16'd0, 16'd0, 32'hFFFF_F000, rcg_pkg::MODE_AUTO);
    push_req(rcg_pkg::OP_TICK, 16'd2000, 16'd1125, 32'h0000_0100, rcg_pkg::MODE_MANUAL);
    push_req(rcg_pkg::OP_TICK, 16'd40000, 16'd1875, 32'hFFFF_FFFF, rcg_pkg::MODE_AUTO);
    push_req(rcg_pkg::OP_SET_MODE, 16'd0, 16'd0, 32'd0, rcg_pkg::MODE_MANUAL);
    clock_ms = 32'd20000;
    fill_random(175);
    wait_drained();

    for (k = 1; k <= 7; k++) begin
      set_phase(k);
      settings_used++;
      clock_ms = (k == 3) ? 32'hFFFF_F000 : $urandom;
      fill_random(210);
      wait_drained();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d of %0d requests over %0d register settings",
             results_taken, accepted, settings_used);
    $display("gestures seen: %0d record, %0d start, %0d kill", n_record, n_start, n_kill);
    if (mismatches == 0 && status_due.size() == 0)
      $display("rc_gesture_mode_controller_tb: done, clean");
    else
      $display("rc_gesture_mode_controller_tb: done, errors");
    $finish;
  end

endmodule

/* rc_gesture_mode_controller.f */
+incdir+rtl
rtl/rcg_pkg.sv
rtl/rc_gesture_mode_controller.sv
rtl/rcg_checker.sv
tb/rc_gesture_mode_controller_tb.sv
